>>> sv/spbp_pkg.sv
// Shared constants, types and helper functions for the sign projection bit packer.
`timescale 1ns / 1ps
`default_nettype none

package spbp_pkg;

  localparam int MAX_BITS    = 256;
  localparam int MAX_DIMS    = 512;
  localparam int VALUE_WIDTH = 16;
  localparam int WORD_BITS   = 64;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int SUM_W       = ACC_W + 1;

  localparam int MAX_WORDS   = (MAX_BITS / WORD_BITS > 4) ? 4 : MAX_BITS / WORD_BITS;

  localparam int BIT_IDX_W   = 8;
  localparam int DIM_IDX_W   = 9;
  localparam int WORD_IDX_W  = 2;
  localparam int WCNT_W      = 3;
  localparam int BIT_CNT_W   = $clog2(WORD_BITS);

  localparam int BITS_CFG_W  = 9;
  localparam int DIMS_CFG_W  = 10;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [WORD_IDX_W-1:0]         word_idx_t;

  // Register map, selected by the word address.
  typedef enum logic [0:0] {
    REG_BITS_IN_USE = 1'b0,
    REG_DIMS_IN_USE = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    PK_IDLE  = 1'b0,
    PK_SHIFT = 1'b1
  } pk_state_e;

  // Controls broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic mac_en;
    logic cap;
    logic shift;
  } cell_ctl_t;

  function automatic logic [WCNT_W-1:0] word_count(input logic [BITS_CFG_W-1:0] bits);
    logic [WCNT_W-1:0] w;
    w = WCNT_W'(bits >> BIT_CNT_W);
    if (w == '0) begin
      w = WCNT_W'(1);
    end else if (w > WCNT_W'(MAX_WORDS)) begin
      w = WCNT_W'(MAX_WORDS);
    end
    return w;
  endfunction

  function automatic logic [DIMS_CFG_W-1:0] dim_count(input logic [DIMS_CFG_W-1:0] dims);
    logic [DIMS_CFG_W-1:0] d;
    d = dims;
    if (d == '0) begin
      d = DIMS_CFG_W'(1);
    end else if (d > DIMS_CFG_W'(MAX_DIMS)) begin
      d = DIMS_CFG_W'(MAX_DIMS);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/spbp_if.sv
// Valid/ready stream interfaces for input items and packed output words.
`timescale 1ns / 1ps
`default_nettype none

interface spbp_in_if;
  import spbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [BIT_IDX_W-1:0] bit_index;
  logic [DIM_IDX_W-1:0] dim_index;
  value_t               value;

  modport source (output valid, mode, bit_index, dim_index, value, input ready);
  modport sink   (input valid, mode, bit_index, dim_index, value, output ready);
endinterface

interface spbp_out_if;
  import spbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] bit_word;
  word_idx_t            word_index;
  logic                 last_word;

  modport source (output valid, bit_word, word_index, last_word, input ready);
  modport sink   (input valid, bit_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

>>> sv/sign_projection_bit_packer.sv
// Top level of the sign projection bit packer: config registers, element pipeline and cell chain.
// A vector's first word appears after its last element has passed the read, multiply and
//   accumulate steps, the capture pulse and the shifting of a full word; further words are
//   assembled one bit per cycle from the head of the cell chain while the output register can take them.
// Throughput: one weight write or vector element per cycle within a vector; after the last
//   element the input is held off until the final word is taken.
// Reset: clears accumulators, element counter, pipeline and handshake state; registers
//   return to 256 bits and 300 dims; weight memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sign_projection_bit_packer import spbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spbp_in_if.sink               in_i,
  spbp_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers. The user must write them only while idle; the block
  // itself does not enforce this, and the live values are used directly by the datapath.
  logic [BITS_CFG_W-1:0] bits_q;
  logic [DIMS_CFG_W-1:0] dims_q;
  reg_idx_e              reg_sel;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= BITS_CFG_W'(256);
      dims_q <= DIMS_CFG_W'(300);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BITS_IN_USE: bits_q <= pwdata[BITS_CFG_W-1:0];
        REG_DIMS_IN_USE: dims_q <= pwdata[DIMS_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BITS_IN_USE: prdata = APB_DATA_W'(bits_q);
      REG_DIMS_IN_USE: prdata = APB_DATA_W'(dims_q);
    endcase
  end

  // Input side. The element counter selects the weight column that every
  // cell reads when an element is accepted. Once the last element of a
  // vector is in, the block stays busy until the final word is delivered.
  logic                 busy_q;
  logic [DIM_IDX_W-1:0] ctr_q;
  logic                 in_fire;
  logic                 elem_fire;
  logic                 elem_last;
  logic                 v1_q, v2_q;
  logic                 last1_q, last2_q;
  logic                 cap_q;
  value_t               elem_q;
  logic                 out_done;

  assign in_i.ready = !busy_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign elem_fire  = in_fire && in_i.mode;
  assign elem_last  = (DIMS_CFG_W'(ctr_q) + DIMS_CFG_W'(1)) >= dim_count(dims_q);
  assign out_done   = out_o.valid && out_o.ready && out_o.last_word;

  // Pipeline: read weight at accept, multiply next cycle, accumulate the
  // cycle after. The capture pulse follows the last accumulate and freezes
  // every cell's sign into its shift bit while clearing the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ctr_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
      cap_q   <= 1'b0;
    end else begin
      v1_q    <= elem_fire;
      last1_q <= elem_fire && elem_last;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      cap_q   <= last2_q;
      if (elem_fire) begin
        ctr_q <= elem_last ? '0 : ctr_q + DIM_IDX_W'(1);
      end
      if (elem_fire && elem_last) begin
        busy_q <= 1'b1;
      end else if (out_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_fire) elem_q <= in_i.value;
  end

  // Cell chain. Each cell owns one output bit: its row of weights and its
  // accumulator. During the drain the sign bits move one cell toward the
  // head per cycle unless the packer stalls, so the lowest-numbered bit leaves first.
  cell_ctl_t         cell_ctl;
  logic              shift;
  logic [MAX_BITS:0] bit_chain;

  assign cell_ctl.rd_en  = elem_fire;
  assign cell_ctl.mul_en = v1_q;
  assign cell_ctl.mac_en = v2_q;
  assign cell_ctl.cap    = cap_q;
  assign cell_ctl.shift  = shift;
  assign bit_chain[MAX_BITS] = 1'b0;

  for (genvar i = 0; i < MAX_BITS; i++) begin : g_cell
    logic wr_sel;
    assign wr_sel = in_fire && !in_i.mode && (in_i.bit_index == BIT_IDX_W'(i));

    spbp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (cell_ctl),
      .wr_en_i   (wr_sel),
      .wr_dim_i  (in_i.dim_index),
      .wr_data_i (in_i.value),
      .rd_dim_i  (ctr_q),
      .elem_i    (elem_q),
      .bit_i     (bit_chain[i+1]),
      .bit_o     (bit_chain[i])
    );
  end

  spbp_packer u_packer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cap_q),
    .nwords_i (word_count(bits_q)),
    .head_i   (bit_chain[0]),
    .shift_o  (shift),
    .out_o    (out_o)
  );

  // The capture pulse follows the closing element through last1_q, last2_q and cap_q.
  a_cap_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elem_fire && elem_last) |-> ##3 cap_q)
    else $error("capture pulse missing after the last element");

  // Words are only produced while a finished vector is being drained.
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> busy_q)
    else $error("output word outside a drain");

  // The drain never overlaps accumulation or input acceptance.
  a_shift_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> (busy_q && !cell_ctl.mac_en && !cell_ctl.mul_en))
    else $error("chain shifting while accumulating");

  // The element counter restarts after the closing element.
  a_ctr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elem_fire && elem_last) |=> (ctr_q == '0))
    else $error("element counter not cleared at end of vector");

endmodule

`default_nettype wire

>>> sv/spbp_cell.sv
// One chain cell: weight row memory, multiply-accumulate and a shifting sign bit.
`timescale 1ns / 1ps
`default_nettype none

module spbp_cell import spbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctl_t            ctl_i,
  input  logic                 wr_en_i,
  input  logic [DIM_IDX_W-1:0] wr_dim_i,
  input  value_t               wr_data_i,
  input  logic [DIM_IDX_W-1:0] rd_dim_i,
  input  value_t               elem_i,
  input  logic                 bit_i,
  output logic                 bit_o
);

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  value_t              weight_mem [MAX_DIMS];
  value_t              weight_q;
  prod_t               prod_q;
  acc_t                acc_q;
  acc_t                acc_d;
  logic [SUM_W-1:0]    sum;
  logic                bit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      weight_mem[wr_dim_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      weight_q <= weight_mem[rd_dim_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= PROD_W'(elem_i) * PROD_W'(weight_q);
    end
  end

  // Saturate when the two top bits of the widened sum disagree.
  always_comb begin
    sum = SUM_W'(acc_q) + SUM_W'(prod_q);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      acc_d = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = acc_t'(sum[ACC_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.cap) begin
      acc_q <= '0;
    end else if (ctl_i.mac_en) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      bit_q <= !acc_q[ACC_W-1] && (|acc_q);
    end else if (ctl_i.shift) begin
      bit_q <= bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule

`default_nettype wire

>>> sv/spbp_packer.sv
// Collects sign bits from the head of the chain into 64-bit words with an output register.
`timescale 1ns / 1ps
`default_nettype none

module spbp_packer import spbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WCNT_W-1:0] nwords_i,
  input  logic              head_i,
  output logic              shift_o,
  spbp_out_if.source        out_o
);

  pk_state_e              state_q;
  pk_state_e              state_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q;
  word_idx_t              widx_q;
  logic [WCNT_W-1:0]      nwords_q;
  logic [WORD_BITS-2:0]   asm_q;
  logic                   out_valid_q;
  logic [WORD_BITS-1:0]   out_word_q;
  word_idx_t              out_idx_q;
  logic                   out_last_q;
  logic                   word_done;
  logic                   last_word;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PK_IDLE: begin
        if (start_i) state_d = PK_SHIFT;
      end
      PK_SHIFT: begin
        if (word_done && last_word) state_d = PK_IDLE;
      end
    endcase
  end

  // A word can only complete when the output register is free or being emptied.
  always_comb begin
    shift_o   = (state_q == PK_SHIFT) &&
                !((bit_cnt_q == '1) && out_valid_q && !out_o.ready);
    word_done = shift_o && (bit_cnt_q == '1);
    last_word = (WCNT_W'(widx_q) + WCNT_W'(1)) == nwords_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PK_IDLE;
      bit_cnt_q   <= '0;
      widx_q      <= '0;
      nwords_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_i) begin
        bit_cnt_q <= '0;
        widx_q    <= '0;
        nwords_q  <= nwords_i;
      end else if (shift_o) begin
        bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
        if (word_done) widx_q <= widx_q + WORD_IDX_W'(1);
      end
      if (word_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_o) begin
      asm_q <= {asm_q[WORD_BITS-3:0], head_i};
    end
    if (word_done) begin
      out_word_q <= {asm_q, head_i};
      out_idx_q  <= widx_q;
      out_last_q <= last_word;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.bit_word   = out_word_q;
  assign out_o.word_index = out_idx_q;
  assign out_o.last_word  = out_last_q;

endmodule

`default_nettype wire
